// ===== hdl/lztbp_pkg.sv =====
// Shared types, constants and helper functions of the LZ token bit packer.
package lztbp_pkg;

    // token kinds carried on the input tuser
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_LIT   = 2'd1,
        OP_MATCH = 2'd2,
        OP_END   = 2'd3
    } t_op;

    localparam int LZ_IN_TDATA_W  = 80;   // 73 payload bits padded to bytes
    localparam int LZ_IN_TUSER_W  = 2;
    localparam int LZ_OUT_TDATA_W = 8;
    localparam int LZ_BUF_BYTES   = 8;    // two words at most per token

    localparam logic [15:0] LZ_MIN_LEN    = 16'd2;
    localparam logic [16:0] LZ_DIST_LIMIT = 17'd130560;
    localparam logic [16:0] LZ_SHORT_DIST = 17'd512;
    localparam logic [3:0]  LZ_LEN_PFX_MAX  = 4'd15;
    localparam logic [2:0]  LZ_DIST_PFX_MAX = 3'd7;
    localparam logic [4:0]  LZ_DIST_BASE    = 5'd9;

    typedef logic [7:0] t_byte;

    // number of significant bits, 0 for zero
    function automatic logic [4:0] f_bitlen16(input logic [15:0] x);
        logic [4:0] r;
        r = 5'd0;
        for (int i = 0; i < 16; i++) begin
            if (x[i]) begin
                r = 5'(i + 1);
            end
        end
        return r;
    endfunction

    function automatic logic [3:0] f_bitlen8(input logic [7:0] x);
        logic [3:0] r;
        r = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (x[i]) begin
                r = 4'(i + 1);
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/lz_token_bit_packer_top.sv =====
// LZ77 token bit packer: codes tokens MSB first and emits the packed stream bytewise.
//
//  channel | dir | handshake                     | contents
//  s_axis  | in  | s_axis_tvalid / s_axis_tready | tdata: size, literal, length, distance
//          |     |                               | tuser: token kind
//  m_axis  | out | m_axis_tvalid / m_axis_tready | tdata: byte, tlast: last, tuser: error
//
// One input register, one combinational coding and packing step, then an
// eight-byte output buffer that drains one byte per cycle while m_axis_tready is high.
// A token that yields no byte passes straight through; a token that yields bytes
// holds the packing step until the buffer drains.
// The next token is taken while the last buffered byte is being delivered.
// Reset (synchronous, active low) empties both stages and clears the accumulator.
module lz_token_bit_packer_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: stream_size[31:0], literal[39:32], length[55:40], distance[72:56], zero pad
    input  logic [lztbp_pkg::LZ_IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: op[1:0]
    input  logic [lztbp_pkg::LZ_IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata: out_byte[7:0]
    output logic [lztbp_pkg::LZ_OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                                  m_axis_tlast,
    // tuser: error
    output logic                                  m_axis_tuser
);
    import lztbp_pkg::*;

    // input register
    logic        r_in_valid;
    t_op         r_op;
    logic [31:0] r_size;
    logic [7:0]  r_lit;
    logic [15:0] r_len;
    logic [16:0] r_dist;

    // packer state
    logic [31:0] r_acc;
    logic [4:0]  r_pend;

    // output buffer
    t_byte       r_obuf [LZ_BUF_BYTES];
    logic [3:0]  r_ocnt;
    logic        r_oerr;

    logic        s_fire;
    logic        m_fire;
    logic        load;

    // coding step
    logic [3:0]  len_n;
    logic [15:0] len_mask;
    logic        len_z;
    logic [4:0]  len_bits;
    logic [31:0] len_code;
    logic [16:0] dist_off;
    logic [7:0]  dist_q;
    logic [2:0]  dist_k;
    logic [6:0]  dist_kmask;
    logic        dist_z;
    logic [4:0]  dist_lowbits;
    logic [16:0] dist_low;
    logic [4:0]  dist_bits;
    logic [31:0] dist_code;
    logic        bad_match;
    logic [63:0] code;
    logic [5:0]  code_bits;
    logic [63:0] code_left;
    logic [31:0] acc_base;
    logic [4:0]  pend_base;
    logic [95:0] win;
    logic [6:0]  total;
    logic [5:0]  flush_sum;

    t_byte       n_obuf [LZ_BUF_BYTES];
    logic [3:0]  n_ocnt;
    logic        n_oerr;
    logic [31:0] n_acc;
    logic [4:0]  n_pend;

    assign m_fire        = m_axis_tvalid && m_axis_tready;
    assign load          = r_in_valid && ((r_ocnt == 4'd0) || ((r_ocnt == 4'd1) && m_fire));
    assign s_axis_tready = !r_in_valid || load;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = (r_ocnt != 4'd0);
    assign m_axis_tdata  = r_obuf[0];
    assign m_axis_tlast  = (r_ocnt == 4'd1);
    assign m_axis_tuser  = r_oerr;

    always_comb begin
        // length code: n ones, a zero unless n is the maximum, n low bits
        len_n    = 4'(f_bitlen16(r_len) - 5'd1);
        len_mask = (16'h1 << len_n) - 16'h1;
        len_z    = (len_n != LZ_LEN_PFX_MAX);
        len_bits = {len_n, 1'b0} + {4'b0, len_z};
        len_code = ({16'b0, len_mask} << ({1'b0, len_n} + {4'b0, len_z}))
                 | {16'b0, r_len & len_mask};

        // distance code
        dist_off = r_dist - LZ_SHORT_DIST;
        dist_q   = {1'b0, dist_off[16:10]} + 8'd1;
        dist_k   = (r_dist < LZ_SHORT_DIST) ? 3'd0 : 3'(f_bitlen8(dist_q));
        dist_kmask   = 7'((8'h1 << dist_k) - 8'h1);
        dist_z       = (dist_k != LZ_DIST_PFX_MAX);
        dist_lowbits = {2'b0, dist_k} + LZ_DIST_BASE;
        dist_low     = (r_dist - {1'b0, dist_kmask, 9'b0})
                     & ((17'h1 << dist_lowbits) - 17'h1);
        dist_bits    = dist_lowbits + {2'b0, dist_k} + {4'b0, dist_z};
        dist_code    = ({25'b0, dist_kmask} << (dist_lowbits + {4'b0, dist_z}))
                     | {15'b0, dist_low};

        bad_match = (r_len < LZ_MIN_LEN) || (r_dist >= LZ_DIST_LIMIT);

        acc_base  = r_acc;
        pend_base = r_pend;
        code      = 64'b0;
        code_bits = 6'd0;
        case (r_op)
            OP_START: begin
                acc_base  = 32'b0;
                pend_base = 5'd0;
                code      = {32'b0, r_size};
                code_bits = 6'd32;
            end
            OP_LIT: begin
                code      = {56'b0, r_lit};
                code_bits = 6'd9;
            end
            OP_MATCH: begin
                code      = ({32'b0, len_code} << dist_bits) | {32'b0, dist_code};
                code_bits = {1'b0, len_bits} + {1'b0, dist_bits};
            end
            default: begin
                code      = 64'b0;
                code_bits = 6'd0;
            end
        endcase

        // left-align the code and place it right after the pending bits
        code_left = code << (7'd64 - {1'b0, code_bits});
        win       = {acc_base, 64'b0} | ({code_left, 32'b0} >> pend_base);
        total     = {2'b0, pend_base} + {1'b0, code_bits};
        flush_sum = {1'b0, r_pend} + 6'd7;

        for (int i = 0; i < LZ_BUF_BYTES; i++) begin
            n_obuf[i] = win[95-8*i -: 8];
        end
        n_ocnt = {total[6:5], 2'b00};
        n_oerr = 1'b0;
        n_acc  = r_acc;
        n_pend = total[4:0];
        case (total[6:5])
            2'd0:    n_acc = win[95:64];
            2'd1:    n_acc = win[63:32];
            default: n_acc = win[31:0];
        endcase

        if (r_op == OP_END) begin
            n_ocnt = {1'b0, flush_sum[5:3]};
            n_acc  = 32'b0;
            n_pend = 5'd0;
        end else if ((r_op == OP_MATCH) && bad_match) begin
            // error transaction only; packer state is left alone
            n_obuf[0] = 8'h00;
            n_ocnt    = 4'd1;
            n_oerr    = 1'b1;
            n_acc     = r_acc;
            n_pend    = r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_ocnt     <= 4'd0;
            r_acc      <= 32'b0;
            r_pend     <= 5'd0;
        end else begin
            if (s_fire) begin
                r_in_valid <= 1'b1;
                r_op       <= t_op'(s_axis_tuser);
                r_size     <= s_axis_tdata[31:0];
                r_lit      <= s_axis_tdata[39:32];
                r_len      <= s_axis_tdata[55:40];
                r_dist     <= s_axis_tdata[72:56];
            end else if (load) begin
                r_in_valid <= 1'b0;
            end

            if (load) begin
                r_obuf <= n_obuf;
                r_ocnt <= n_ocnt;
                r_oerr <= n_oerr;
                r_acc  <= n_acc;
                r_pend <= n_pend;
            end else if (m_fire) begin
                for (int i = 0; i < LZ_BUF_BYTES - 1; i++) begin
                    r_obuf[i] <= r_obuf[i+1];
                end
                r_ocnt <= r_ocnt - 4'd1;
            end
        end
    end

`ifndef SYNTH
    // bits below the pending count are always clear
    a_acc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc & (32'hFFFF_FFFF >> r_pend)) == 32'b0)
        else $error("accumulator holds bits past the pending count");

    a_err_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && (r_op == OP_MATCH) && bad_match)
        |=> (r_acc == $past(r_acc)) && (r_pend == $past(r_pend)) && (r_ocnt == 4'd1))
        else $error("rejected match changed the packer state");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && (r_op == OP_END)) |=> (r_acc == 32'b0) && (r_pend == 5'd0))
        else $error("flush left pending bits");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ocnt > 4'd1) |-> !load)
        else $error("token loaded over undelivered bytes");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == 8'h00)))
        else $error("error transaction is not a lone zero byte");
`endif

endmodule
